// File: rtl/wca_pkg.sv
package wca_pkg;

	localparam int SIZE_W    = 16;
	localparam int TOTAL_W   = 20;
	localparam int HOLD_W    = 7;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAPACITY  = 1'b0,
		CFG_HOLD_TIME = 1'b1
	} cfg_idx_t;

	typedef logic [SIZE_W-1:0]  size_t;
	typedef logic [TOTAL_W-1:0] total_t;
	typedef logic [HOLD_W-1:0]  hold_t;

endpackage

// File: rtl/wca_ifs.sv
interface wca_req_if;
	logic                      valid;
	logic                      ready;
	logic [wca_pkg::SIZE_W-1:0] request_size;

	modport source (output valid, output request_size, input ready);
	modport sink   (input valid, input request_size, output ready);
endinterface

interface wca_res_if;
	logic valid;
	logic ready;
	logic admitted;

	modport source (output valid, output admitted, input ready);
	modport sink   (input valid, input admitted, output ready);
endinterface

// File: rtl/wca_cell.sv
module wca_cell #(
	parameter int IDX   = 0,
	parameter int TAP_W = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift,
	input  logic [TAP_W-1:0]           tap,
	input  logic [wca_pkg::SIZE_W-1:0] din,
	output logic [wca_pkg::SIZE_W-1:0] dout,
	output logic [wca_pkg::SIZE_W-1:0] tap_out
);
	import wca_pkg::*;

	size_t size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
		end else if (shift) begin
			size_q <= din;
		end
	end

	assign dout = size_q;

	// drive the release bus only when this cell sits at the selected age
	assign tap_out = (tap == TAP_W'(IDX)) ? size_q : '0;

endmodule

// File: rtl/windowed_capacity_admission_core.sv
// Channel  Role    Payload              Handshake
// -------  ------  -------------------  ----------------------
// req      sink    request_size[15:0]   valid/ready
// res      source  admitted             valid/ready
// cfg      write   cfg_index, cfg_data  cfg_we, no wait
//
// One request per cycle: release, add and capacity compare complete in the
// accept cycle; the answer sits in the output register the next cycle.
// Throughput is set by the single total register; a stalled res only
// blocks req when the output register is full and not being taken.
// Reset clears the delay cells and the running total and sets capacity (0)
// and hold_time (1); no clearing pass is needed.
module windowed_capacity_admission_core #(
	parameter int MAX_HOLD = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	wca_req_if.sink                       req,
	wca_res_if.source                     res,
	input  logic                          cfg_we,
	input  logic [wca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wca_pkg::CFG_W-1:0]     cfg_data
);
	import wca_pkg::*;

	localparam int TAP_W = (MAX_HOLD > 1) ? $clog2(MAX_HOLD) : 1;

	total_t             cap_q;
	hold_t              hold_q;
	total_t             total_q;
	logic               out_valid_q;
	logic               admitted_q;

	logic               acc;
	logic [TAP_W-1:0]   tap;
	size_t              new_entry;
	size_t              released;
	total_t             after_rel;
	logic [TOTAL_W:0]   sum;
	logic               admit;
	size_t              line  [MAX_HOLD];
	size_t              taps  [MAX_HOLD];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= '0;
			hold_q <= HOLD_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CAPACITY:  cap_q  <= cfg_data[TOTAL_W-1:0];
				CFG_HOLD_TIME: hold_q <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// age of the entry to release: clamp hold_time into 1..MAX_HOLD
	always_comb begin
		if (hold_q == '0) begin
			tap = '0;
		end else if (32'(hold_q) > MAX_HOLD) begin
			tap = TAP_W'(MAX_HOLD - 1);
		end else begin
			tap = TAP_W'(32'(hold_q) - 1);
		end
	end

	assign req.ready = !out_valid_q || res.ready;
	assign acc       = req.valid && req.ready;

	// delay line: cell k holds the entry written k+1 transactions ago
	for (genvar k = 0; k < MAX_HOLD; k++) begin : g_cell
		wca_cell #(
			.IDX   (k),
			.TAP_W (TAP_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (acc),
			.tap     (tap),
			.din     ((k == 0) ? new_entry : line[(k == 0) ? 0 : k-1]),
			.dout    (line[k]),
			.tap_out (taps[k])
		);
	end

	always_comb begin
		released = '0;
		for (int k = 0; k < MAX_HOLD; k++) begin
			released = released | taps[k];
		end
	end

	always_comb begin
		if (TOTAL_W'(released) >= total_q) begin
			after_rel = '0;
		end else begin
			after_rel = total_q - TOTAL_W'(released);
		end
		sum       = {1'b0, after_rel} + (TOTAL_W+1)'(req.request_size);
		admit     = sum <= {1'b0, cap_q};
		new_entry = admit ? req.request_size : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (acc) begin
			total_q <= admit ? sum[TOTAL_W-1:0] : after_rel;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			admitted_q <= admit;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.admitted = admitted_q;

	a_total_fits: assert property (@(posedge clk) disable iff (!arst_n)
		acc && admit |=> total_q <= $past(cap_q))
		else $error("held total exceeds capacity after admit");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> out_valid_q)
		else $error("accepted request produced no pending result");

	a_total_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(total_q))
		else $error("held total changed without a transaction");

endmodule

// File: sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import wca_pkg::*;

	localparam int LINE_DEPTH  = 64;
	localparam int POS_W       = $clog2(LINE_DEPTH);
	localparam int RANDOM_REQS = 1600;
	localparam int PRINT_LIMIT = 40;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	wca_req_if req_ch ();
	wca_res_if res_ch ();

	windowed_capacity_admission_core #(
		.MAX_HOLD(LINE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	// predictor state: register copies, delay line, running total
	total_t           cap_setting  = '0;
	hold_t            hold_setting = 7'd1;
	size_t            held_line [LINE_DEPTH] = '{default: '0};
	total_t           held_sum     = '0;
	logic [POS_W-1:0] line_wr_pos  = '0;

	logic admit_queue [$];

	int mismatch_count = 0;
	int requests_sent  = 0;
	int admitted_seen  = 0;
	int rejected_seen  = 0;
	int register_writes = 0;
	int send_idle_max  = 9;
	int recv_idle_max  = 9;

	function automatic logic predict_admission(input size_t sz);
		int unsigned      eff_hold;
		logic [POS_W-1:0] rd_slot;
		size_t            released;
		logic [TOTAL_W:0] trial;
		logic             ok;
		eff_hold = 32'(hold_setting);
		if (eff_hold == 0)
			eff_hold = 1;
		if (eff_hold > LINE_DEPTH)
			eff_hold = LINE_DEPTH;
		rd_slot  = line_wr_pos - POS_W'(eff_hold);
		released = held_line[rd_slot];
		// release first; the total floors at zero
		if (TOTAL_W'(released) >= held_sum)
			held_sum = '0;
		else
			held_sum = held_sum - TOTAL_W'(released);
		trial = {1'b0, held_sum} + (TOTAL_W+1)'(sz);
		ok    = (trial <= {1'b0, cap_setting});
		if (ok) begin
			held_sum = trial[TOTAL_W-1:0];
			held_line[line_wr_pos] = sz;
		end else begin
			held_line[line_wr_pos] = '0;
		end
		line_wr_pos = line_wr_pos + POS_W'(1);
		return ok;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic send_request(input size_t sz);
		int gap;
		gap = $urandom_range(0, send_idle_max);
		repeat (gap) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.request_size <= sz;
		do @(posedge clk); while (!req_ch.ready);
		admit_queue.push_back(predict_admission(sz));
		requests_sent++;
	endtask

	// hold the sender until every pending answer is back
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		while (admit_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_register(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_CAPACITY:  cap_setting  = value[TOTAL_W-1:0];
			CFG_HOLD_TIME: hold_setting = value[HOLD_W-1:0];
			default: ;
		endcase
		register_writes++;
	endtask

	// result checker
	always @(posedge clk) begin
		logic predicted;
		if (res_ch.valid && res_ch.ready) begin
			if (admit_queue.size() == 0) begin
				report_mismatch($sformatf("result admitted=%b with no request pending",
					res_ch.admitted));
			end else begin
				predicted = admit_queue.pop_front();
				if (res_ch.admitted !== predicted)
					report_mismatch($sformatf("admitted=%b, predicted %b",
						res_ch.admitted, predicted));
				if (predicted)
					admitted_seen++;
				else
					rejected_seen++;
			end
		end
	end

	// result receiver with random stalls
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, recv_idle_max);
			repeat (stall) begin
				res_ch.ready <= 1'b0;
				@(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// registers at their reset values: capacity 0, hold 1
	task automatic test_reset_state();
		send_request(16'd0);
		send_request(16'd1);
		send_request(16'hFFFF);
	endtask

	// early steps release nothing, then each size leaves after the hold time
	task automatic test_release_window();
		wait_for_results();
		set_register(CFG_CAPACITY, 20'd100);
		set_register(CFG_HOLD_TIME, 20'd3);
		send_request(16'd60);
		send_request(16'd50);
		send_request(16'd40);
		send_request(16'd30);
		send_request(16'd100);
		send_request(16'd0);
	endtask

	task automatic test_capacity_extremes();
		wait_for_results();
		set_register(CFG_CAPACITY, 20'hFFFFF);
		set_register(CFG_HOLD_TIME, 20'd64);
		send_request(16'hFFFF);
		send_request(16'hFFFF);
		send_request(16'd0);
		send_request(16'd1);
	endtask

	// capacity dropped under the held total: even a zero size is refused
	task automatic test_capacity_lowered();
		wait_for_results();
		set_register(CFG_CAPACITY, 20'd200);
		set_register(CFG_HOLD_TIME, 20'd8);
		send_request(16'd150);
		send_request(16'd10);
		wait_for_results();
		set_register(CFG_CAPACITY, 20'd100);
		send_request(16'd0);
	endtask

	// shorten the hold with sizes in flight; upper data bits must be dropped
	task automatic test_hold_change();
		wait_for_results();
		set_register(CFG_HOLD_TIME, 20'hABC82);
		send_request(16'd5);
		send_request(16'd0);
		send_request(16'd1);
	endtask

	// zero acts as one, values above the line depth saturate
	task automatic test_hold_out_of_range();
		wait_for_results();
		set_register(CFG_CAPACITY, 20'd50);
		set_register(CFG_HOLD_TIME, 20'hFFF80);
		send_request(16'd30);
		send_request(16'd30);
		send_request(16'd30);
		wait_for_results();
		set_register(CFG_HOLD_TIME, 20'h0007F);
		send_request(16'd20);
		send_request(16'd40);
	endtask

	task automatic test_random_traffic();
		int               sent;
		int               phase_len;
		int               eff_hold;
		int               scale;
		logic [CFG_W-1:0] value;
		size_t            sz;
		sent = 0;
		while (sent < RANDOM_REQS) begin
			wait_for_results();
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 5))
					0:       value = '0;
					1:       value = 20'hFFFFF;
					2:       value = CFG_W'($urandom);
					default: value = CFG_W'($urandom_range(0, 300000));
				endcase
				set_register(CFG_CAPACITY, value);
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 7))
					0:       value = 20'd1;
					1:       value = 20'd64;
					2:       value = $urandom_range(0, 1) ? 20'd0 :
						CFG_W'($urandom_range(65, 127));
					default: value = CFG_W'($urandom_range(1, 64));
				endcase
				value[CFG_W-1:HOLD_W] = (CFG_W-HOLD_W)'($urandom);
				set_register(CFG_HOLD_TIME, value);
			end
			send_idle_max = $urandom_range(0, 1) ? 9 : 0;
			recv_idle_max = $urandom_range(0, 1) ? 9 : 0;

			// pick sizes on the scale where admit and reject both happen
			eff_hold = (hold_setting == 0) ? 1 :
				(hold_setting > LINE_DEPTH) ? LINE_DEPTH : int'(hold_setting);
			scale = 2 * int'(cap_setting) / eff_hold + 1;
			if (scale > 65535)
				scale = 65535;

			phase_len = $urandom_range(40, 160);
			for (int i = 0; i < phase_len; i++) begin
				if ($urandom_range(0, 199) == 0)
					wait_for_results();
				case ($urandom_range(0, 7))
					0:       sz = '0;
					1:       sz = 16'hFFFF;
					2, 3:    sz = SIZE_W'($urandom);
					default: sz = SIZE_W'($urandom_range(0, scale));
				endcase
				send_request(sz);
			end
			sent += phase_len;
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.request_size = '0;
		cfg_we              = 1'b0;
		cfg_index           = CFG_CAPACITY;
		cfg_data            = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_release_window();
		test_capacity_extremes();
		test_capacity_lowered();
		test_hold_change();
		test_hold_out_of_range();
		test_random_traffic();

		wait_for_results();
		repeat (8) @(posedge clk);
		if (admit_queue.size() != 0)
			report_mismatch($sformatf("%0d answers never arrived", admit_queue.size()));

		$display("Sent %0d requests under %0d register writes: %0d admitted, %0d rejected.",
			requests_sent, register_writes, admitted_seen, rejected_seen);
		$display("Capacity and hold extremes, out-of-range hold and hold changes were covered.");
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Run timed out with %0d answers pending.", admit_queue.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: filelist.f
rtl/wca_pkg.sv
rtl/wca_ifs.sv
rtl/wca_cell.sv
rtl/windowed_capacity_admission_core.sv
sim/testbench.sv
